// ===== sv/vertex_normal_averager_assert.svh =====
// ----------------------------------------------------------------------------
// Vertex normal averager assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_AVERAGER_ASSERT_SVH
`define VERTEX_NORMAL_AVERAGER_ASSERT_SVH

// same-cycle implication on i_clk, off during reset
`define VNA_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("vertex_normal_averager: assertion failed");

// next-cycle implication on i_clk, off during reset
`define VNA_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("vertex_normal_averager: assertion failed");

`endif

// ===== sv/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex normal averager package
// Shared constants and codes for the averager and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vna_pkg;

    localparam int VERTEX_COUNT_DEF = 256;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TRI  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic signed [20:0] ACC_MAX = 21'sd524287;
    localparam logic signed [20:0] ACC_MIN = -21'sd524288;

    localparam logic [14:0] UNIT_ONE = 15'd16384;

    typedef logic signed [15:0] t_coord;
    typedef logic signed [19:0] t_acc;

endpackage

// ===== sv/vertex_normal_averager.sv =====
// ----------------------------------------------------------------------------
// Vertex normal averager
// Per-vertex smooth normals from a triangle stream, kept in two vertex memories.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  request  | in        | i_valid / o_stall  | mode, indices, position
//  normal   | out       | o_valid / i_stall  | index, normal xyz, degenerate
//
//  Load: written on acceptance. Triangle: position reads, cross product, magnitude,
//  shift, squares, square root, three divides and three accumulator updates; read:
//  accumulator read, the same normalize steps and output. A zero vector ends after
//  the magnitude step. The bit-serial square root and divides take longest.
//  After reset the accumulator memory is cleared entry by entry.
//  A finished normal waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_normal_averager #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [7:0]         i_vertex_index,
    input  logic [7:0]         i_corner_b,
    input  logic [7:0]         i_corner_c,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_index,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic               o_degenerate
);

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_CLR    = 15'b000000000000010,
        S_PRD    = 15'b000000000000100,
        S_XMUL   = 15'b000000000001000,
        S_RRD    = 15'b000000000010000,
        S_RWAIT  = 15'b000000000100000,
        S_NPREP  = 15'b000000001000000,
        S_NSHIFT = 15'b000000010000000,
        S_NSQ    = 15'b000000100000000,
        S_NSQRT  = 15'b000001000000000,
        S_NDINIT = 15'b000010000000000,
        S_NDIV   = 15'b000100000000000,
        S_ACC_RD = 15'b001000000000000,
        S_ACC_WR = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    function automatic logic in_range(input logic [7:0] idx);
        return ({24'd0, idx} < 32'(VERTEX_COUNT));
    endfunction

    function automatic logic [19:0] sat_add(input vna_pkg::t_acc a, input vna_pkg::t_coord b);
        logic signed [20:0] s;
        s = 21'(a) + 21'(b);
        if (s > vna_pkg::ACC_MAX) begin
            return vna_pkg::ACC_MAX[19:0];
        end else if (s < vna_pkg::ACC_MIN) begin
            return vna_pkg::ACC_MIN[19:0];
        end
        return s[19:0];
    endfunction

    logic [47:0] pos_mem [VERTEX_COUNT];
    logic [59:0] acc_mem [VERTEX_COUNT];

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr;
    logic [3:0]           r_cnt;
    logic                 r_tri;
    logic [7:0]           r_idx [3];
    vna_pkg::t_coord      r_pos [3][3];
    logic [47:0]          r_pos_q;
    logic [59:0]          r_acc_q;
    logic signed [33:0]   r_prod;
    logic signed [35:0]   r_vec [3];
    logic                 r_neg [3];
    logic [34:0]          r_mag [3];
    logic [59:0]          r_sqp;
    logic [61:0]          r_sqv;
    logic [61:0]          r_root;
    logic [61:0]          r_bit;
    logic [1:0]           r_comp;
    logic [31:0]          r_rem;
    logic [14:0]          r_numlo;
    logic [14:0]          r_q;
    vna_pkg::t_coord      r_n [3];
    logic                 r_zero;
    logic                 r_out_valid;
    logic [7:0]           r_out_index;
    vna_pkg::t_coord      r_out_n [3];
    logic                 r_out_deg;

    logic                 accept;
    logic                 out_free;
    logic                 tri_ok;
    logic [7:0]           sel_idx;
    logic                 pos_we;
    logic                 acc_we;
    logic [AW-1:0]        acc_waddr;
    logic [59:0]          acc_wdata;
    logic signed [16:0]   e1 [3];
    logic signed [16:0]   e2 [3];
    logic signed [16:0]   ma, mb;
    logic [29:0]          sq_op;
    logic                 mag_big;
    logic                 mag_zero;
    logic [61:0]          rt_sum;
    logic [30:0]          len;
    logic [34:0]          div_mag;
    logic [44:0]          div_num;
    logic [31:0]          div_t;
    logic                 div_ge;
    logic [14:0]          q_fin;
    logic [14:0]          q_sat;
    vna_pkg::t_coord      q_sgn;
    logic [2:0]           xj;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign tri_ok   = in_range(i_vertex_index) && in_range(i_corner_b) && in_range(i_corner_c);

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sel_idx = r_idx[0];
            2'd1:    sel_idx = r_idx[1];
            default: sel_idx = r_idx[2];
        endcase
    end

    assign pos_we = accept && (i_mode == vna_pkg::MODE_LOAD) && in_range(i_vertex_index);

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = AW'(sel_idx);
        acc_wdata = '0;
        if (r_state == S_CLR) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr;
        end else if (pos_we) begin
            acc_we    = 1'b1;
            acc_waddr = AW'(i_vertex_index);
        end else if (r_state == S_ACC_WR) begin
            acc_we    = 1'b1;
            acc_wdata = {sat_add(r_acc_q[59:40], r_n[0]),
                         sat_add(r_acc_q[39:20], r_n[1]),
                         sat_add(r_acc_q[19:0],  r_n[2])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[AW'(i_vertex_index)] <= {i_pos_x, i_pos_y, i_pos_z};
        end
        r_pos_q <= pos_mem[AW'(sel_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        r_acc_q <= acc_mem[AW'(sel_idx)];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = 17'(r_pos[1][i]) - 17'(r_pos[0][i]);
            e2[i] = 17'(r_pos[2][i]) - 17'(r_pos[0][i]);
        end
        case (r_cnt[2:0])
            3'd0:    begin ma = e1[1]; mb = e2[2]; end
            3'd1:    begin ma = e1[2]; mb = e2[1]; end
            3'd2:    begin ma = e1[2]; mb = e2[0]; end
            3'd3:    begin ma = e1[0]; mb = e2[2]; end
            3'd4:    begin ma = e1[0]; mb = e2[1]; end
            default: begin ma = e1[1]; mb = e2[0]; end
        endcase
        xj = r_cnt[2:0] - 3'd1;
    end

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_op = r_mag[0][29:0];
            2'd1:    sq_op = r_mag[1][29:0];
            default: sq_op = r_mag[2][29:0];
        endcase
        mag_big  = (r_mag[0][34:30] != '0) || (r_mag[1][34:30] != '0)
                || (r_mag[2][34:30] != '0);
        mag_zero = (r_vec[0] == '0) && (r_vec[1] == '0) && (r_vec[2] == '0);
        rt_sum   = r_root + r_bit;
        len      = r_root[30:0];
        case (r_comp)
            2'd0:    div_mag = r_mag[0];
            2'd1:    div_mag = r_mag[1];
            default: div_mag = r_mag[2];
        endcase
        div_num = {div_mag[29:0], 15'd0} >> 1;
        div_num = div_num + 45'(len >> 1);
        div_t   = {r_rem[30:0], r_numlo[14]};
        div_ge  = (div_t >= {1'b0, len});
        q_fin   = {r_q[13:0], div_ge};
        q_sat   = (q_fin > vna_pkg::UNIT_ONE) ? vna_pkg::UNIT_ONE : q_fin;
        q_sgn   = r_neg[r_comp] ? -16'(q_sat) : 16'(q_sat);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_mode == vna_pkg::MODE_TRI && tri_ok) begin
                    n_state = S_PRD;
                end else if (accept && i_mode == vna_pkg::MODE_READ) begin
                    n_state = in_range(i_vertex_index) ? S_RRD : S_NPREP;
                end
            end
            S_CLR:    if (r_clr == AW'(VERTEX_COUNT - 1)) n_state = S_IDLE;
            S_PRD:    if (r_cnt == 4'd3) n_state = S_XMUL;
            S_XMUL:   if (r_cnt == 4'd6) n_state = S_NPREP;
            S_RRD:    n_state = S_RWAIT;
            S_RWAIT:  n_state = S_NPREP;
            S_NPREP: begin
                if (!mag_zero) begin
                    n_state = S_NSHIFT;
                end else begin
                    n_state = r_tri ? S_IDLE : S_OUT;
                end
            end
            S_NSHIFT: if (!mag_big) n_state = S_NSQ;
            S_NSQ:    if (r_cnt == 4'd3) n_state = S_NSQRT;
            S_NSQRT:  if (r_bit[0]) n_state = S_NDINIT;
            S_NDINIT: n_state = S_NDIV;
            S_NDIV: begin
                if (r_cnt == 4'd14) begin
                    if (r_comp != 2'd2) begin
                        n_state = S_NDINIT;
                    end else begin
                        n_state = r_tri ? S_ACC_RD : S_OUT;
                    end
                end
            end
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: if (r_cnt == 4'd2) n_state = S_IDLE; else n_state = S_ACC_RD;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ACC_WR) begin
                r_cnt <= r_cnt + 4'd1;
            end else if (r_state != n_state && !(r_state == S_ACC_RD)) begin
                r_cnt <= '0;
            end else if (r_state == S_ACC_RD || r_state == S_NSHIFT) begin
                r_cnt <= r_cnt;
            end else begin
                r_cnt <= r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_tri    <= (i_mode == vna_pkg::MODE_TRI);
                r_idx[0] <= i_vertex_index;
                r_idx[1] <= i_corner_b;
                r_idx[2] <= i_corner_c;
                for (int i = 0; i < 3; i++) begin
                    r_vec[i] <= '0;
                end
            end
            S_PRD: begin
                if (r_cnt != 4'd0) begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[r_cnt[1:0] - 2'd1][i] <= r_pos_q[47 - 16*i -: 16];
                    end
                end
            end
            S_XMUL: begin
                r_prod <= ma * mb;
                if (r_cnt != 4'd0) begin
                    if (!xj[0]) begin
                        r_vec[xj[2:1]] <= 36'(r_prod);
                    end else begin
                        r_vec[xj[2:1]] <= r_vec[xj[2:1]] - 36'(r_prod);
                    end
                end
            end
            S_RWAIT: begin
                r_vec[0] <= 36'($signed(r_acc_q[59:40]));
                r_vec[1] <= 36'($signed(r_acc_q[39:20]));
                r_vec[2] <= 36'($signed(r_acc_q[19:0]));
            end
            S_NPREP: begin
                r_zero <= mag_zero;
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_vec[i][35];
                    r_mag[i] <= r_vec[i][35] ? 35'(-r_vec[i]) : 35'(r_vec[i]);
                    r_n[i]   <= '0;
                end
            end
            S_NSHIFT: begin
                if (mag_big) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end
                r_sqv <= '0;
            end
            S_NSQ: begin
                r_sqp <= sq_op * sq_op;
                if (r_cnt != 4'd0) begin
                    r_sqv <= r_sqv + 62'(r_sqp);
                end
                r_root <= '0;
                r_bit  <= 62'(1) << 60;
                r_comp <= 2'd0;
            end
            S_NSQRT: begin
                if (r_sqv >= rt_sum) begin
                    r_sqv  <= r_sqv - rt_sum;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_NDINIT: begin
                r_rem   <= 32'(div_num[44:15]);
                r_numlo <= div_num[14:0];
                r_q     <= '0;
            end
            S_NDIV: begin
                r_rem   <= div_ge ? (div_t - {1'b0, len}) : div_t;
                r_numlo <= r_numlo << 1;
                r_q     <= q_fin;
                if (r_cnt == 4'd14) begin
                    r_n[r_comp] <= q_sgn;
                    r_comp      <= r_comp + 2'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_index <= r_idx[0];
                    r_out_n     <= r_n;
                    r_out_deg   <= r_zero;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_out_index  = r_out_index;
    assign o_normal_x   = r_out_n[0];
    assign o_normal_y   = r_out_n[1];
    assign o_normal_z   = r_out_n[2];
    assign o_degenerate = r_out_deg;

endmodule

// ===== sv/vna_checker.sv =====
// ----------------------------------------------------------------------------
// Vertex normal averager port checker
// Watches the result channel of the averager over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vertex_normal_averager_assert.svh"

module vna_checker #(
    parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [7:0]         o_out_index,
    input logic signed [15:0] o_normal_x,
    input logic signed [15:0] o_normal_y,
    input logic signed [15:0] o_normal_z,
    input logic               o_degenerate
);

    function automatic logic in_unit(input logic signed [15:0] v);
        return (v >= -16'sd16384) && (v <= 16'sd16384);
    endfunction

    logic [56:0] out_bits;

    assign out_bits = {o_out_index, o_normal_x, o_normal_y, o_normal_z, o_degenerate};

    `VNA_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(out_bits))

    `VNA_ASSERT_NOW(a_unit, o_valid, in_unit(o_normal_x) && in_unit(o_normal_y) && in_unit(o_normal_z))

    `VNA_ASSERT_NOW(a_deg_zero, o_valid && o_degenerate, {o_normal_x, o_normal_y, o_normal_z} == '0)

    `VNA_ASSERT_NOW(a_range, o_valid && ({24'd0, o_out_index} >= 32'(VERTEX_COUNT)), o_degenerate)

endmodule

bind vertex_normal_averager vna_checker #(.VERTEX_COUNT(VERTEX_COUNT)) u_vna_checker (.*);
